// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SUKT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SUKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sukt_pkg.sv -----
`default_nettype none

package sukt_pkg;

	localparam int CAPACITY  = 32;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 16;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 5;
	localparam int CNT_OUT_W = 6;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [VAL_W-1:0]  val_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_DUP     = 2'd1,
		STAT_MISSING = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		key_t  key;
		val_t  val;
	} wr_t;

endpackage

`default_nettype wire

// ----- rtl/sukt_req_if.sv -----
`default_nettype none

interface sukt_req_if;
	logic                          valid;
	logic                          ready;
	logic [sukt_pkg::ACT_W-1:0]    action;
	logic [sukt_pkg::KEY_W-1:0]    key;
	logic [sukt_pkg::VAL_W-1:0]    value;

	modport source(output valid, output action, output key, output value, input ready);
	modport sink(input valid, input action, input key, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/sukt_rsp_if.sv -----
`default_nettype none

interface sukt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [sukt_pkg::STAT_W-1:0]     status;
	logic [sukt_pkg::POS_W-1:0]      position;
	logic [sukt_pkg::VAL_W-1:0]      found_value;
	logic [sukt_pkg::CNT_OUT_W-1:0]  entry_count;

	modport source(output valid, output status, output position, output found_value,
		output entry_count, input ready);
	modport sink(input valid, input status, input position, input found_value,
		input entry_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/sukt_store.sv -----
`default_nettype none

module sukt_store (
	input  wire logic            clk,
	input  wire sukt_pkg::wr_t   wr,
	input  wire sukt_pkg::addr_t rd_addr,
	output sukt_pkg::key_t       rd_key,
	output sukt_pkg::val_t       rd_val
);

	sukt_pkg::key_t key_mem [sukt_pkg::CAPACITY];
	sukt_pkg::val_t val_mem [sukt_pkg::CAPACITY];
	sukt_pkg::key_t rd_key_q;
	sukt_pkg::val_t rd_val_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr] <= wr.key;
			val_mem[wr.addr] <= wr.val;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule

`default_nettype wire

// ----- rtl/sorted_unique_key_table.sv -----
// Lookup, delete and insert scan up from slot 0 to the key, a larger key or the last entry;
// on an empty table an insert writes slot 0 and the others miss. A successful insert moves
// each entry at or above its slot up one place and writes the new entry; a successful delete
// moves each entry above it down one place. The result waits in EMIT until the output register
// is free. One item in work at a time; ready rises at the edge that registers the result.
// Reset clears the entry count and all handshake state; store contents stay undefined.
`default_nettype none

module sorted_unique_key_table (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sukt_req_if.sink    req,
	sukt_rsp_if.source  rsp
);

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		SHIFT_UP,
		SHIFT_DN,
		WRITE,
		EMIT
	} state_t;

	state_t                    state_q;
	sukt_pkg::action_t         act_q;
	sukt_pkg::key_t            key_q;
	sukt_pkg::val_t            val_q;
	sukt_pkg::addr_t           ptr_q;
	sukt_pkg::addr_t           pos_q;
	sukt_pkg::cnt_t            used_count_q;
	sukt_pkg::status_t         res_status_q;
	sukt_pkg::addr_t           res_pos_q;
	sukt_pkg::val_t            res_fval_q;
	logic                      rsp_valid_q;
	sukt_pkg::status_t         out_status_q;
	logic [sukt_pkg::POS_W-1:0]     out_pos_q;
	sukt_pkg::val_t            out_fval_q;
	logic [sukt_pkg::CNT_OUT_W-1:0] out_cnt_q;

	sukt_pkg::wr_t   wr;
	sukt_pkg::addr_t rd_addr;
	sukt_pkg::key_t  rd_key;
	sukt_pkg::val_t  rd_val;

	sukt_pkg::addr_t ptr_next;
	sukt_pkg::addr_t ptr_prev;
	sukt_pkg::addr_t last_slot;
	logic            key_eq;
	logic            key_gt;
	logic            last_scan;
	logic            last_dn;
	logic            tbl_full;
	logic            shift_start;

	sukt_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val)
	);

	// shared compare unit
	assign key_eq = (rd_key == key_q);
	assign key_gt = (rd_key > key_q);

	assign ptr_next  = ptr_q + sukt_pkg::ADDR_W'(1);
	assign ptr_prev  = ptr_q - sukt_pkg::ADDR_W'(1);
	assign last_slot = sukt_pkg::ADDR_W'(used_count_q - sukt_pkg::CNT_W'(1));
	assign last_scan = ((sukt_pkg::CNT_W'(ptr_q) + sukt_pkg::CNT_W'(1)) == used_count_q);
	assign last_dn   = last_scan;
	assign tbl_full  = (used_count_q == sukt_pkg::CNT_W'(sukt_pkg::CAPACITY));
	// insert that lands below existing entries: start moving from the top
	assign shift_start = (act_q == sukt_pkg::ACT_INSERT) && !key_eq && key_gt && !tbl_full;

	always_comb begin
		case (state_q)
			IDLE:     rd_addr = '0;
			SCAN:     rd_addr = shift_start ? last_slot : ptr_next;
			SHIFT_UP: rd_addr = ptr_prev;
			SHIFT_DN: rd_addr = ptr_next;
			default:  rd_addr = ptr_q;
		endcase
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = ptr_q;
		wr.key  = rd_key;
		wr.val  = rd_val;
		case (state_q)
			SHIFT_UP: begin
				wr.en   = 1'b1;
				wr.addr = ptr_next;
			end
			SHIFT_DN: begin
				wr.en   = 1'b1;
				wr.addr = ptr_prev;
			end
			WRITE: begin
				wr.en   = 1'b1;
				wr.addr = pos_q;
				wr.key  = key_q;
				wr.val  = val_q;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			act_q        <= sukt_pkg::ACT_INSERT;
			key_q        <= '0;
			val_q        <= '0;
			ptr_q        <= '0;
			pos_q        <= '0;
			used_count_q <= '0;
			res_status_q <= sukt_pkg::STAT_OK;
			res_pos_q    <= '0;
			res_fval_q   <= '0;
			rsp_valid_q  <= 1'b0;
			out_status_q <= sukt_pkg::STAT_OK;
			out_pos_q    <= '0;
			out_fval_q   <= '0;
			out_cnt_q    <= '0;
		end else begin
			// in EMIT the output register is reloaded below instead
			if (rsp_valid_q && rsp.ready && state_q != EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req.valid) begin
						act_q        <= sukt_pkg::action_t'(req.action);
						key_q        <= req.key;
						val_q        <= req.value;
						ptr_q        <= '0;
						pos_q        <= '0;
						res_status_q <= sukt_pkg::STAT_OK;
						res_pos_q    <= '0;
						res_fval_q   <= '0;
						case (sukt_pkg::action_t'(req.action))
							sukt_pkg::ACT_INSERT: begin
								state_q <= (used_count_q == '0) ? WRITE : SCAN;
							end
							sukt_pkg::ACT_DELETE, sukt_pkg::ACT_LOOKUP: begin
								if (used_count_q == '0) begin
									res_status_q <= sukt_pkg::STAT_MISSING;
									state_q      <= EMIT;
								end else begin
									state_q <= SCAN;
								end
							end
							default: begin
								state_q <= EMIT;
							end
						endcase
					end
				end
				SCAN: begin
					if (key_eq || key_gt || last_scan) begin
						case (act_q)
							sukt_pkg::ACT_INSERT: begin
								if (key_eq) begin
									res_status_q <= sukt_pkg::STAT_DUP;
									state_q      <= EMIT;
								end else if (tbl_full) begin
									res_status_q <= sukt_pkg::STAT_FULL;
									state_q      <= EMIT;
								end else if (key_gt) begin
									pos_q     <= ptr_q;
									res_pos_q <= ptr_q;
									ptr_q     <= last_slot;
									state_q   <= SHIFT_UP;
								end else begin
									pos_q     <= ptr_next;
									res_pos_q <= ptr_next;
									state_q   <= WRITE;
								end
							end
							sukt_pkg::ACT_DELETE: begin
								if (!key_eq) begin
									res_status_q <= sukt_pkg::STAT_MISSING;
									state_q      <= EMIT;
								end else begin
									res_pos_q <= ptr_q;
									if (last_scan) begin
										used_count_q <= used_count_q - sukt_pkg::CNT_W'(1);
										state_q      <= EMIT;
									end else begin
										ptr_q   <= ptr_next;
										state_q <= SHIFT_DN;
									end
								end
							end
							sukt_pkg::ACT_LOOKUP: begin
								if (key_eq) begin
									res_pos_q  <= ptr_q;
									res_fval_q <= rd_val;
								end else begin
									res_status_q <= sukt_pkg::STAT_MISSING;
								end
								state_q <= EMIT;
							end
							default: begin
								state_q <= EMIT;
							end
						endcase
					end else begin
						ptr_q <= ptr_next;
					end
				end
				SHIFT_UP: begin
					// the entry just moved sat in the insertion slot
					if (ptr_q == pos_q) begin
						state_q <= WRITE;
					end else begin
						ptr_q <= ptr_prev;
					end
				end
				SHIFT_DN: begin
					if (last_dn) begin
						used_count_q <= used_count_q - sukt_pkg::CNT_W'(1);
						state_q      <= EMIT;
					end else begin
						ptr_q <= ptr_next;
					end
				end
				WRITE: begin
					used_count_q <= used_count_q + sukt_pkg::CNT_W'(1);
					state_q      <= EMIT;
				end
				EMIT: begin
					// hold the result until the output register frees up
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_pos_q    <= sukt_pkg::POS_W'(res_pos_q);
						out_fval_q   <= res_fval_q;
						out_cnt_q    <= sukt_pkg::CNT_OUT_W'(used_count_q);
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.position    = out_pos_q;
	assign rsp.found_value = out_fval_q;
	assign rsp.entry_count = out_cnt_q;

	`SUKT_ASSERT(a_count_bound, clk, arst_n,
		used_count_q <= sukt_pkg::CNT_W'(sukt_pkg::CAPACITY), "entry count above capacity")
	`SUKT_ASSERT(a_write_state, clk, arst_n,
		!wr.en || state_q == SHIFT_UP || state_q == SHIFT_DN || state_q == WRITE,
		"store written outside a shift or write step")
	`SUKT_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req.valid && req.ready, !req.ready,
		"input taken again before the item finished")
	`SUKT_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		used_count_q == $past(used_count_q) ||
		used_count_q == $past(used_count_q) + sukt_pkg::CNT_W'(1) ||
		used_count_q == $past(used_count_q) - sukt_pkg::CNT_W'(1),
		"entry count moved by more than one")

endmodule

`default_nettype wire
